FILE: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/otsu_pkg.sv
// ----------------------------------------------------------------------------
// Otsu threshold package
// Shared constants for the Otsu threshold block.
// ----------------------------------------------------------------------------
package otsu_pkg;
  localparam int BINS_DEF       = 128;
  localparam int MAX_PIXELS_DEF = 32768;
  localparam int CNT_W          = 16;
  localparam int PIX_W          = 8;
  localparam logic CFG_TMIN = 1'b0;
  localparam logic CFG_TMAX = 1'b1;
endpackage

FILE: src/otsu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module otsu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/otsu_threshold_from_histogram.sv
// ----------------------------------------------------------------------------
// Otsu threshold from histogram
// Counts a frame of gray pixels into a histogram and picks the Otsu threshold.
// ----------------------------------------------------------------------------
// Usage: pixels arrive on the s_axis channel, tdata[7:0] is the gray value and
// tlast marks the final pixel of a frame. One pixel is accepted per cycle while
// a frame is counted; each transaction reads its bin from the histogram RAM,
// and the increment is written back in the next cycle, with forwarding when two
// consecutive pixels hit the same bin.
// After the last pixel the block stops accepting input, waits until the
// last write lands, then makes three passes over the RAM: a sum pass, a
// search pass through a shared 32x32 multiplier (a skipped bin takes states
// ST_SRD, ST_ACC and ST_MAG, a candidate bin also ST_SQ, ST_CMP and ST_OUT)
// and a clearing pass. The threshold then moves into the m_axis output
// register and counting of the next frame starts at once. In the worst case
// the time from the last pixel to m_axis_tvalid is set by the multiplier
// sequence of the search.
// If the receiver stalls, the threshold waits in the output register; a
// second result that finds it still full waits after its clearing pass.
// Reset clears the histogram through the same clearing pass before the first
// pixel is accepted and sets threshold_min 0, max 255.
// Configuration writes via cfg_we/cfg_addr/cfg_data take effect at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module otsu_threshold_from_histogram #(
  parameter int BINS       = otsu_pkg::BINS_DEF,
  parameter int MAX_PIXELS = otsu_pkg::MAX_PIXELS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] threshold
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [7:0] cfg_data
);
  import otsu_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int TW = AW + 1;           // loop counter that can hold BINS
  localparam int NW = CNT_W + AW;       // total pixel count
  localparam int SW = CNT_W + 2 * AW;   // weighted sum

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_COUNT = 4'd1;
  localparam logic [3:0] ST_SUM   = 4'd2;
  localparam logic [3:0] ST_SRD   = 4'd3;
  localparam logic [3:0] ST_ACC   = 4'd4;
  localparam logic [3:0] ST_MAG   = 4'd5;
  localparam logic [3:0] ST_SQ    = 4'd6;
  localparam logic [3:0] ST_CMP   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0] state;
  logic [7:0] tmin, tmax;

  // RAM ports
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [CNT_W-1:0] wdata, rdata;

  otsu_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Counting pipeline
  logic          p_vld;
  logic [AW-1:0] p_bin;
  logic          f_vld;       // previous write, for forwarding
  logic [AW-1:0] f_bin;
  logic [CNT_W-1:0] f_val;
  logic          p_last;
  logic [CNT_W-1:0] cur, inc;
  logic [AW-1:0] in_bin;

  always_comb begin
    if ({2'b0, s_axis_tdata[7:1]} >= 9'(BINS)) begin
      in_bin = AW'(BINS - 1);
    end else begin
      in_bin = AW'(s_axis_tdata[7:1]);
    end
    cur = (f_vld && f_bin == p_bin) ? f_val : rdata;
    inc = (cur < CNT_W'(MAX_PIXELS)) ? cur + 1'b1 : cur;
  end

  assign s_axis_tready = (state == ST_COUNT) && !p_last;
  wire in_acc = s_axis_tvalid && s_axis_tready;

  // Search datapath
  logic [TW-1:0]   t;
  logic [NW-1:0]   total, cnt0;
  logic [SW-1:0]   wsum, sum0;
  logic [63:0]     a, b, mag;
  logic [127:0]    sq, best_sq;
  logic [63:0]     den, best_den;
  logic [AW-1:0]   best;
  logic [191:0]    lhs, rhs;
  logic [2:0]      step;
  logic [31:0]     ma, mb;
  logic [63:0]     prod;
  logic [7:0]      result;
  logic [7:0]      out_data;
  logic            cand;
  logic            out_load;

  // One 32x32 product per cycle, registered.
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  logic [CNT_W-1:0] h;
  assign h = rdata;

  // Multiplier operand selection for sequenced wide products.
  logic [1:0] mphase;  // 0: square, 1: lhs, 2: rhs
  logic [3:0] mcnt;
  logic [3:0] pidx;    // index of the product that arrives this cycle
  assign pidx = mcnt - 1'b1;
  always_comb begin
    ma = '0;
    mb = '0;
    case (mphase)
      2'd0: begin
        ma = mcnt[1] ? mag[63:32] : mag[31:0];
        mb = mcnt[0] ? mag[63:32] : mag[31:0];
      end
      2'd1: begin
        ma = sq[32*mcnt[2:1] +: 32];
        mb = mcnt[0] ? best_den[63:32] : best_den[31:0];
      end
      2'd2: begin
        ma = best_sq[32*mcnt[2:1] +: 32];
        mb = mcnt[0] ? den[63:32] : den[31:0];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  logic [NW-1:0] cnt1;
  assign cnt1 = total - cnt0;
  assign cand = (9'(t) >= {2'b0, tmin[7:1]}) && (9'(t) < {2'b0, tmax[7:1]}) &&
                (cnt0 != '0) && (cnt1 != '0);

  // The output register takes the result when it is empty or drains now.
  assign out_load = (state == ST_DONE) && (t == TW'(BINS)) &&
                    (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    we    = 1'b0;
    waddr = p_bin;
    wdata = inc;
    raddr = in_bin;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = t[AW-1:0];
        wdata = '0;
      end
      ST_COUNT: begin
        we = p_vld;
      end
      ST_SUM, ST_SRD: begin
        raddr = t[AW-1:0];
      end
      ST_DONE: begin
        we    = 1'b1;
        waddr = t[AW-1:0];
        wdata = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      t        <= '0;
      tmin     <= 8'd0;
      tmax     <= 8'd255;
      p_vld    <= 1'b0;
      f_vld    <= 1'b0;
      p_last   <= 1'b0;
      m_axis_tvalid <= 1'b0;
      step     <= '0;
      mcnt     <= '0;
      mphase   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_TMIN) tmin <= cfg_data;
        else tmax <= cfg_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (t == TW'(BINS - 1)) begin
            t     <= '0;
            state <= ST_COUNT;
          end else begin
            t <= t + 1'b1;
          end
        end
        ST_COUNT: begin
          p_vld <= in_acc;
          p_bin <= in_bin;
          f_bin <= p_bin;
          f_val <= inc;
          if (p_last && !p_vld) begin
            // Last write has landed; start summing.
            p_last <= 1'b0;
            f_vld  <= 1'b0;
            t      <= '0;
            total  <= '0;
            wsum   <= '0;
            state  <= ST_SUM;
          end else begin
            f_vld <= p_vld;
            if (in_acc && s_axis_tlast) p_last <= 1'b1;
          end
        end
        ST_SUM: begin
          // Read address t, data arrives next cycle for bin t-1.
          if (t != '0) begin
            total <= total + NW'(h);
            wsum  <= wsum + SW'(h) * SW'(t - 1'b1);
          end
          if (t == TW'(BINS)) begin
            t        <= '0;
            cnt0     <= '0;
            sum0     <= '0;
            best_sq  <= '0;
            best_den <= 64'd1;
            best     <= '0;
            state    <= ST_SRD;
          end else begin
            t <= t + 1'b1;
          end
        end
        ST_SRD: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          cnt0  <= cnt0 + NW'(h);
          sum0  <= sum0 + SW'(h) * SW'(t);
          state <= ST_MAG;
        end
        ST_MAG: begin
          if (!cand) begin
            if (t == TW'(BINS - 1)) begin
              t     <= '0;
              result <= 8'({best, 1'b0});
              state <= ST_DONE;
            end else begin
              t     <= t + 1'b1;
              state <= ST_SRD;
            end
          end else begin
            a      <= 64'(total) * 64'(sum0);
            b      <= 64'(wsum) * 64'(cnt0);
            den    <= 64'(cnt0) * 64'(cnt1);
            step   <= 3'd0;
            state  <= ST_SQ;
            mphase <= 2'd0;
            mcnt   <= '0;
            sq     <= '0;
            lhs    <= '0;
            rhs    <= '0;
          end
        end
        ST_SQ: begin
          // Step 0 forms |a-b|; then 4 partial products of the square.
          if (step == 3'd0) begin
            mag  <= (a > b) ? a - b : b - a;
            step <= 3'd1;
          end else begin
            if (mcnt != 4'd0) begin
              sq <= sq + (128'(prod) << (32 * (pidx[1] + pidx[0])));
            end
            if (mcnt == 4'd4) begin
              mcnt   <= '0;
              mphase <= 2'd1;
              state  <= ST_CMP;
            end else begin
              mcnt <= mcnt + 1'b1;
            end
          end
        end
        ST_CMP: begin
          // 8 products for lhs, then 8 for rhs, each a limb shift.
          if (mcnt != 4'd0) begin
            if (mphase == 2'd1) begin
              lhs <= lhs + (192'(prod) << (32 * (pidx[2:1] + pidx[0])));
            end else begin
              rhs <= rhs + (192'(prod) << (32 * (pidx[2:1] + pidx[0])));
            end
          end
          if (mcnt == 4'd8) begin
            mcnt <= '0;
            if (mphase == 2'd1) begin
              mphase <= 2'd2;
            end else begin
              mphase <= 2'd0;
              state  <= ST_OUT;
            end
          end else begin
            mcnt <= mcnt + 1'b1;
          end
        end
        ST_OUT: begin
          // Compare stage of the search.
          if (lhs > rhs) begin
            best_sq  <= sq;
            best_den <= den;
            best     <= t[AW-1:0];
          end
          if (t == TW'(BINS - 1)) begin
            t     <= '0;
            result <= (lhs > rhs) ? 8'({t[AW-1:0], 1'b0}) : 8'({best, 1'b0});
            state <= ST_DONE;
          end else begin
            t     <= t + 1'b1;
            state <= ST_SRD;
          end
        end
        ST_DONE: begin
          // Clearing pass, then hand the result to the output register.
          if (t == TW'(BINS)) begin
            if (out_load) begin
              out_data <= result;
              t        <= '0;
              state    <= ST_COUNT;
            end
          end else begin
            t <= t + 1'b1;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  assign m_axis_tdata = out_data;

  `ASSERT_IMPL(a_no_in_when_busy, state != ST_COUNT, !s_axis_tready,
    "input ready outside counting")
  `ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
    "result dropped under stall")
  `ASSERT_IMPL(a_even, m_axis_tvalid, !m_axis_tdata[0], "odd threshold")
endmodule
